// File: src/ethernet_rx_frame_classifier_assert.svh
// Assertion macros shared by the frame classifier modules.
`ifndef ETHERNET_RX_FRAME_CLASSIFIER_ASSERT_SVH
`define ETHERNET_RX_FRAME_CLASSIFIER_ASSERT_SVH

// Implication that must hold at every clock edge outside reset.
`define ERFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Condition that must hold on the cycle after the antecedent.
`define ERFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/erfc_pkg.sv
package erfc_pkg;

	// Verdict codes.
	localparam logic [3:0] V_ECHO_OK    = 4'd0;
	localparam logic [3:0] V_ARP_LEARN  = 4'd1;
	localparam logic [3:0] V_ARP_IGNORE = 4'd2;
	localparam logic [3:0] V_IP_OTHER   = 4'd3;
	localparam logic [3:0] V_ETH_SHORT  = 4'd4;
	localparam logic [3:0] V_BAD_KIND   = 4'd5;
	localparam logic [3:0] V_ARP_SHORT  = 4'd6;
	localparam logic [3:0] V_IP_SHORT   = 4'd7;
	localparam logic [3:0] V_IP_LEN     = 4'd8;
	localparam logic [3:0] V_IP_CKSUM   = 4'd9;
	localparam logic [3:0] V_IP_DEST    = 4'd10;
	localparam logic [3:0] V_ICMP_SHORT = 4'd11;
	localparam logic [3:0] V_ICMP_CKSUM = 4'd12;
	localparam logic [3:0] V_ICMP_TYPE  = 4'd13;

	localparam logic [15:0] KIND_ARP  = 16'h0806;
	localparam logic [15:0] KIND_IPV4 = 16'h0800;
	localparam logic [15:0] SUM_OK    = 16'hffff;
	localparam logic [15:0] ARP_REPLY = 16'd2;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  ICMP_REQUEST = 8'd8;
	localparam logic [7:0]  ICMP_REPLY   = 8'd0;
	localparam logic [31:0] HOST_IP_RST = 32'd167772687;
	localparam logic [31:0] NHOP_IP_RST = 32'd167772674;

	localparam logic CFG_HOST_IP = 1'b0;
	localparam logic CFG_NHOP_IP = 1'b1;

	// Whole-frame summary handed from the parser to the judge.
	typedef struct packed {
		logic [14:0] len;
		logic [15:0] kind;
		logic [15:0] ip_sum;
		logic [15:0] icmp_sum;
		logic [7:0]  hold;
		logic [3:0]  hwords;
		logic [15:0] total_len;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  icmp_type;
		logic [31:0] id_seq;
		logic [15:0] arp_op;
		logic [47:0] arp_mac;
		logic [31:0] arp_ip;
	} frame_sum_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [7:0]  icmp_kind;
		logic [15:0] echo_id;
		logic [15:0] echo_sequence;
		logic [31:0] source_ip;
		logic [47:0] gateway_mac;
	} result_t;

	// One's-complement add with end-around carry.
	function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

// File: src/ethernet_rx_frame_classifier.sv
// Path of a frame: parser output register, summary queue, judge result register.
// Throughput: one byte, or one-byte frame, per cycle unless the output stalls.
// The parser stage and a two-entry summary queue decouple input from the judge.
// Reset (arst_n low, asynchronous) clears frame state and empties the queue;
// the gateway MAC resets to broadcast and the addresses to their defaults.
module ethernet_rx_frame_classifier #(
	parameter int MAX_FRAME = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // data_byte
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// verdict[3:0], icmp_kind[11:4], echo_id[27:12], echo_sequence[43:28],
	// source_ip[75:44], gateway_mac[123:76], zero fill [127:124]
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	logic                 p_valid;
	erfc_pkg::frame_sum_t p_data;
	logic                 p_ready;
	logic                 f_valid;
	erfc_pkg::frame_sum_t f_data;
	logic                 f_ready;
	erfc_pkg::result_t    res;

	erfc_parse #(.MAX_FRAME(MAX_FRAME)) u_parse (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_last(s_axis_tlast),
		.in_ready(s_axis_tready),
		.sum_valid(p_valid), .sum_data(p_data), .sum_ready(p_ready)
	);

	erfc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(p_valid), .wr_data(p_data), .wr_ready(p_ready),
		.rd_valid(f_valid), .rd_data(f_data), .rd_ready(f_ready)
	);

	erfc_judge u_judge (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.sum_valid(f_valid), .sum_data(f_data), .sum_ready(f_ready),
		.res_valid(m_axis_tvalid), .res_data(res), .res_ready(m_axis_tready)
	);

	assign m_axis_tdata = {4'd0, res.gateway_mac, res.source_ip, res.echo_sequence,
		res.echo_id, res.icmp_kind, res.verdict};

endmodule

// File: src/erfc_parse.sv
`include "ethernet_rx_frame_classifier_assert.svh"
// Front part: walks frame bytes and accumulates header fields and sums.
module erfc_parse #(
	parameter int MAX_FRAME = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	output logic                   in_ready,
	output logic                   sum_valid,
	output erfc_pkg::frame_sum_t   sum_data,
	input  logic                   sum_ready
);

	localparam logic [14:0] MAXF = 15'(MAX_FRAME);

	erfc_pkg::frame_sum_t cur_q;
	erfc_pkg::frame_sum_t nxt;
	logic                 out_valid_q;
	erfc_pkg::frame_sum_t out_q;
	logic                 take;
	logic [14:0]          q;
	logic [14:0]          hl;
	logic [14:0]          r;
	logic [15:0]          word;

	assign in_ready  = !out_valid_q || sum_ready;
	assign take      = in_valid && in_ready;
	assign sum_valid = out_valid_q;
	assign sum_data  = out_q;

	// Per-byte field capture, mirroring the header layout.
	always_comb begin
		nxt  = cur_q;
		q    = cur_q.len - 15'd14;
		hl   = {9'd0, cur_q.hwords, 2'b00};
		r    = q - hl;
		word = {cur_q.hold, in_byte};
		if (cur_q.len < MAXF) begin
			nxt.len = cur_q.len + 15'd1;
			if (cur_q.len == 15'd12) nxt.kind = {in_byte, 8'd0};
			if (cur_q.len == 15'd13) nxt.kind = {cur_q.kind[15:8], in_byte};
			if (cur_q.len >= 15'd14) begin
				if (cur_q.kind == erfc_pkg::KIND_ARP) begin
					if (q == 15'd6 || q == 15'd7)
						nxt.arp_op = {cur_q.arp_op[7:0], in_byte};
					else if (q >= 15'd8 && q < 15'd14)
						nxt.arp_mac = {cur_q.arp_mac[39:0], in_byte};
					else if (q >= 15'd14 && q < 15'd18)
						nxt.arp_ip = {cur_q.arp_ip[23:0], in_byte};
				end else if (cur_q.kind == erfc_pkg::KIND_IPV4) begin
					if (q == 15'd0) nxt.hwords = in_byte[3:0];
					if (q == 15'd2 || q == 15'd3)
						nxt.total_len = {cur_q.total_len[7:0], in_byte};
					if (q == 15'd9) nxt.proto = in_byte;
					if (q >= 15'd12 && q < 15'd16) nxt.src = {cur_q.src[23:0], in_byte};
					if (q >= 15'd16 && q < 15'd20) nxt.dst = {cur_q.dst[23:0], in_byte};
					if (!q[0]) nxt.hold = in_byte;
					else if (q < hl) nxt.ip_sum = erfc_pkg::ones_add(cur_q.ip_sum, word);
					else if (cur_q.hwords >= 4'd5)
						nxt.icmp_sum = erfc_pkg::ones_add(cur_q.icmp_sum, word);
					if (cur_q.hwords >= 4'd5 && q >= hl) begin
						if (r == 15'd0) begin
							nxt.icmp_type = in_byte;
							nxt.id_seq    = 32'd0;
						end else if (r >= 15'd4 && r < 15'd8)
							nxt.id_seq = {cur_q.id_seq[23:0], in_byte};
					end
				end
			end
		end
	end

	// Running frame state and the output stage toward the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sum_ready) out_valid_q <= 1'b0;
			if (take) begin
				if (in_last) begin
					cur_q       <= '0;
					out_valid_q <= 1'b1;
				end else begin
					cur_q <= nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_last) out_q <= nxt;
	end

	`ERFC_ASSERT_NEXT(a_len_clear, clk, arst_n, take && in_last, cur_q.len == 15'd0)
	`ERFC_ASSERT_IMP(a_len_cap, clk, arst_n, 1'b1, cur_q.len <= MAXF)
	`ERFC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !sum_ready, out_valid_q)

endmodule

// File: src/erfc_fifo.sv
`include "ethernet_rx_frame_classifier_assert.svh"
// Short queue between front and back parts.
module erfc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	input  erfc_pkg::frame_sum_t wr_data,
	output logic                 wr_ready,
	output logic                 rd_valid,
	output erfc_pkg::frame_sum_t rd_data,
	input  logic                 rd_ready
);

	erfc_pkg::frame_sum_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	`ERFC_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'd2)

endmodule

// File: src/erfc_judge.sv
`include "ethernet_rx_frame_classifier_assert.svh"
// Back part: turns a frame summary into a verdict, keeps the gateway MAC.
module erfc_judge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [31:0]          cfg_data,
	input  logic                 sum_valid,
	input  erfc_pkg::frame_sum_t sum_data,
	output logic                 sum_ready,
	output logic                 res_valid,
	output erfc_pkg::result_t    res_data,
	input  logic                 res_ready
);

	logic [31:0]       host_ip_q;
	logic [31:0]       nhop_ip_q;
	logic [47:0]       gw_mac_q;
	logic              valid_q;
	erfc_pkg::result_t res_q;
	erfc_pkg::result_t res;
	logic [3:0]        v;
	logic [14:0]       pl;
	logic [14:0]       hl;
	logic [14:0]       il;
	logic [15:0]       isum;
	logic              learn;
	logic              icmp_out;
	logic              src_out;

	assign sum_ready = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res_data  = res_q;

	// Verdict ladder.
	always_comb begin
		pl    = (sum_data.len >= 15'd14) ? sum_data.len - 15'd14 : 15'd0;
		hl    = {9'd0, sum_data.hwords, 2'b00};
		il    = pl - hl;
		isum  = il[0] ? erfc_pkg::ones_add(sum_data.icmp_sum, {sum_data.hold, 8'd0})
		              : sum_data.icmp_sum;
		learn = 1'b0;
		if (sum_data.len < 15'd14) v = erfc_pkg::V_ETH_SHORT;
		else if (sum_data.kind == erfc_pkg::KIND_ARP) begin
			if (pl < 15'd18) v = erfc_pkg::V_ARP_SHORT;
			else if (sum_data.arp_op == erfc_pkg::ARP_REPLY && sum_data.arp_ip == nhop_ip_q) begin
				v     = erfc_pkg::V_ARP_LEARN;
				learn = 1'b1;
			end else v = erfc_pkg::V_ARP_IGNORE;
		end else if (sum_data.kind == erfc_pkg::KIND_IPV4) begin
			if (pl < 15'd20 || sum_data.hwords < 4'd5 || hl > pl) v = erfc_pkg::V_IP_SHORT;
			else if ({1'b0, sum_data.total_len} > {2'b00, pl}) v = erfc_pkg::V_IP_LEN;
			else if (sum_data.ip_sum != erfc_pkg::SUM_OK) v = erfc_pkg::V_IP_CKSUM;
			else if (sum_data.dst != host_ip_q) v = erfc_pkg::V_IP_DEST;
			else if (sum_data.proto != erfc_pkg::PROTO_ICMP) v = erfc_pkg::V_IP_OTHER;
			else if (il < 15'd8) v = erfc_pkg::V_ICMP_SHORT;
			else if (isum != erfc_pkg::SUM_OK) v = erfc_pkg::V_ICMP_CKSUM;
			else if (sum_data.icmp_type == erfc_pkg::ICMP_REQUEST ||
			         sum_data.icmp_type == erfc_pkg::ICMP_REPLY) v = erfc_pkg::V_ECHO_OK;
			else v = erfc_pkg::V_ICMP_TYPE;
		end else v = erfc_pkg::V_BAD_KIND;
		icmp_out = v == erfc_pkg::V_ECHO_OK || v == erfc_pkg::V_ICMP_CKSUM ||
		           v == erfc_pkg::V_ICMP_TYPE;
		src_out  = icmp_out || v == erfc_pkg::V_IP_OTHER || v == erfc_pkg::V_IP_LEN ||
		           v == erfc_pkg::V_IP_CKSUM || v == erfc_pkg::V_IP_DEST ||
		           v == erfc_pkg::V_ICMP_SHORT;
		res.verdict       = v;
		res.icmp_kind     = icmp_out ? sum_data.icmp_type : 8'd0;
		res.echo_id       = icmp_out ? sum_data.id_seq[31:16] : 16'd0;
		res.echo_sequence = icmp_out ? sum_data.id_seq[15:0] : 16'd0;
		res.source_ip     = src_out ? sum_data.src : 32'd0;
		res.gateway_mac   = learn ? sum_data.arp_mac : gw_mac_q;
	end

	// Registers, gateway MAC and the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_ip_q <= erfc_pkg::HOST_IP_RST;
			nhop_ip_q <= erfc_pkg::NHOP_IP_RST;
			gw_mac_q  <= '1;
			valid_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == erfc_pkg::CFG_HOST_IP) host_ip_q <= cfg_data;
			if (cfg_we && cfg_idx == erfc_pkg::CFG_NHOP_IP) nhop_ip_q <= cfg_data;
			if (res_ready) valid_q <= 1'b0;
			if (sum_valid && sum_ready) begin
				valid_q <= 1'b1;
				if (learn) gw_mac_q <= sum_data.arp_mac;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid && sum_ready) res_q <= res;
	end

	`ERFC_ASSERT_NEXT(a_learn_mac, clk, arst_n, sum_valid && sum_ready && learn,
		gw_mac_q == res_q.gateway_mac)
	`ERFC_ASSERT_IMP(a_verdict_range, clk, arst_n, valid_q, res_q.verdict <= erfc_pkg::V_ICMP_TYPE)

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import erfc_pkg::*;

	localparam int MAX_FRAME = 2048;

	// Kinds of defect that a built IPv4 frame may carry.
	typedef enum int {
		FL_NONE, FL_LEN, FL_IPSUM, FL_ICMPSUM, FL_DEST, FL_SHORT_ICMP, FL_IHL
	} flaw_t;

	typedef struct {
		logic [7:0] b;
		logic       l;
	} word_t;

	typedef struct {
		logic [3:0]  verdict;
		logic [7:0]  kind;
		logic [15:0] id;
		logic [15:0] seq;
		logic [31:0] src;
		logic [47:0] mac;
	} verdict_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic         cfg_index = CFG_HOST_IP;
	logic [31:0]  cfg_data = 32'd0;

	ethernet_rx_frame_classifier #(.MAX_FRAME(MAX_FRAME)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata), .s_axis_tlast(s_tlast),
		.m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	word_t      pending[$];
	verdict_t   verdicts_due[$];
	logic [7:0] fr[$];
	bit         idle_on = 1'b1;
	logic       long_hold = 1'b0;
	int         errors = 0;
	int         words_in = 0;
	int         frames_checked = 0;
	int         verdict_seen[16];

	// Classifier state as the predictor tracks it.
	logic [31:0] own_ip, gw_ip;
	logic [47:0] gw_mac;
	int          pos;
	logic [15:0] ethtype, hdr_sum, msg_sum, tot_len, arp_op;
	logic [7:0]  hi_hold, proto, msg_type;
	logic [3:0]  ihl;
	logic [31:0] src_ip, dst_ip, id_seq, arp_ip;
	logic [47:0] arp_mac;

	function automatic logic [15:0] fold_add(logic [15:0] a, logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, w};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	task automatic clear_parse();
		pos = 0; ethtype = 0; hdr_sum = 0; msg_sum = 0; tot_len = 0; arp_op = 0;
		hi_hold = 0; proto = 0; msg_type = 0; ihl = 0; src_ip = 0; dst_ip = 0;
		id_seq = 0; arp_ip = 0; arp_mac = 0;
	endtask

	// Per-byte field capture and running header and message sums.
	task automatic absorb(int p, logic [7:0] b);
		int q, hl, r;
		if (p == 12) ethtype[15:8] = b;
		if (p == 13) ethtype[7:0] = b;
		if (p < 14) return;
		q = p - 14;
		if (ethtype == KIND_ARP) begin
			if (q == 6 || q == 7) arp_op = {arp_op[7:0], b};
			else if (q >= 8 && q < 14) arp_mac = {arp_mac[39:0], b};
			else if (q >= 14 && q < 18) arp_ip = {arp_ip[23:0], b};
			return;
		end
		if (ethtype != KIND_IPV4) return;
		if (q == 0) ihl = b[3:0];
		if (q == 2 || q == 3) tot_len = {tot_len[7:0], b};
		if (q == 9) proto = b;
		if (q >= 12 && q < 16) src_ip = {src_ip[23:0], b};
		if (q >= 16 && q < 20) dst_ip = {dst_ip[23:0], b};
		hl = ihl * 4;
		if (q % 2 == 0) begin
			hi_hold = b;
		end else if (q < hl) begin
			hdr_sum = fold_add(hdr_sum, {hi_hold, b});
		end else if (ihl >= 5) begin
			msg_sum = fold_add(msg_sum, {hi_hold, b});
		end
		if (ihl >= 5 && q >= hl) begin
			r = q - hl;
			if (r == 0) msg_type = b;
			else if (r >= 4 && r < 8) id_seq = {id_seq[23:0], b};
		end
	endtask

	function automatic logic [3:0] judge_ip(int pl);
		int hl;
		hl = ihl * 4;
		if (pl < 20 || ihl < 5 || hl > pl) return V_IP_SHORT;
		if (tot_len > pl) return V_IP_LEN;
		if (hdr_sum != SUM_OK) return V_IP_CKSUM;
		if (dst_ip != own_ip) return V_IP_DEST;
		if (proto != PROTO_ICMP) return V_IP_OTHER;
		if (pl - hl < 8) return V_ICMP_SHORT;
		if ((pl - hl) % 2 == 1) msg_sum = fold_add(msg_sum, {hi_hold, 8'd0});
		if (msg_sum != SUM_OK) return V_ICMP_CKSUM;
		if (msg_type == ICMP_REQUEST || msg_type == ICMP_REPLY) return V_ECHO_OK;
		return V_ICMP_TYPE;
	endfunction

	// Advance the predictor by one accepted word; queue a verdict on the last byte.
	task automatic predict_word(logic [7:0] b, logic l);
		verdict_t e;
		int pl;
		if (pos < MAX_FRAME) begin
			absorb(pos, b);
			pos++;
		end
		if (!l) return;
		pl = (pos >= 14) ? pos - 14 : 0;
		if (pos < 14) begin
			e.verdict = V_ETH_SHORT;
		end else if (ethtype == KIND_ARP) begin
			if (pl < 18) begin
				e.verdict = V_ARP_SHORT;
			end else if (arp_op == ARP_REPLY && arp_ip == gw_ip) begin
				gw_mac = arp_mac;
				e.verdict = V_ARP_LEARN;
			end else begin
				e.verdict = V_ARP_IGNORE;
			end
		end else if (ethtype == KIND_IPV4) begin
			e.verdict = judge_ip(pl);
		end else begin
			e.verdict = V_BAD_KIND;
		end
		e.kind = 0; e.id = 0; e.seq = 0; e.src = 0;
		if (e.verdict inside {V_ECHO_OK, V_ICMP_CKSUM, V_ICMP_TYPE}) begin
			e.kind = msg_type;
			e.id = id_seq[31:16];
			e.seq = id_seq[15:0];
		end
		if (e.verdict inside {V_ECHO_OK, V_ICMP_CKSUM, V_ICMP_TYPE, V_IP_OTHER, V_IP_LEN,
				V_IP_CKSUM, V_IP_DEST, V_ICMP_SHORT})
			e.src = src_ip;
		e.mac = gw_mac;
		verdicts_due.push_back(e);
		clear_parse();
	endtask

	// Sender: presents pending words with random gaps and holds on backpressure.
	int s_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_word(s_tdata, s_tlast);
				words_in++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (s_gap > 0) begin
					s_gap <= s_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					s_gap <= $urandom_range(0, 4);
					s_tvalid <= 1'b0;
				end else begin
					w = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= w.b;
					s_tlast <= w.l;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus the long hold-off when requested.
	int m_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_gap <= 0;
		end else if (long_hold) begin
			m_tready <= 1'b0;
		end else if (m_gap > 0) begin
			m_gap <= m_gap - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			m_gap <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Verdict checker: compares each accepted word with the oldest prediction.
	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected verdict word %h", m_tdata);
			end else begin
				e = verdicts_due.pop_front();
				frames_checked++;
				verdict_seen[m_tdata[3:0]]++;
				if (m_tdata[3:0] !== e.verdict || m_tdata[11:4] !== e.kind ||
						m_tdata[27:12] !== e.id || m_tdata[43:28] !== e.seq ||
						m_tdata[75:44] !== e.src || m_tdata[123:76] !== e.mac) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp v=%0d t=%h id=%h sq=%h src=%h mac=%h, got %h",
							e.verdict, e.kind, e.id, e.seq, e.src, e.mac, m_tdata[123:0]);
				end
			end
		end
	end

	function automatic logic [15:0] sum_bytes(int a, int b);
		logic [15:0] s;
		s = 0;
		for (int i = a; i < b; i += 2)
			s = fold_add(s, {fr[i], (i + 1 < b) ? fr[i + 1] : 8'd0});
		return s;
	endfunction

	task automatic push_frame();
		word_t w;
		for (int i = 0; i < fr.size(); i++) begin
			w.b = fr[i];
			w.l = (i == fr.size() - 1);
			pending.push_back(w);
		end
	endtask

	task automatic eth_head(logic [15:0] k);
		fr.delete();
		repeat (12) fr.push_back($urandom_range(0, 255));
		fr.push_back(k[15:8]);
		fr.push_back(k[7:0]);
	endtask

	task automatic put32(logic [31:0] v);
		for (int i = 3; i >= 0; i--) fr.push_back(v[8 * i +: 8]);
	endtask

	// IPv4 frame with an ICMP message or other payload, optionally flawed.
	task automatic build_ip(int hw, logic [7:0] pr, logic [31:0] dst, logic [7:0] ity,
			int ndata, int pad, flaw_t fl);
		int h, m, n;
		logic [15:0] c;
		eth_head(KIND_IPV4);
		h = fr.size();
		fr.push_back({4'd4, hw[3:0]});
		fr.push_back($urandom_range(0, 255));
		fr.push_back(0); fr.push_back(0);
		repeat (5) fr.push_back($urandom_range(0, 255));
		fr.push_back(pr);
		fr.push_back(0); fr.push_back(0);
		put32($urandom);
		put32(fl == FL_DEST ? ~dst : dst);
		repeat (((hw < 5 ? 5 : hw) - 5) * 4) fr.push_back($urandom_range(0, 255));
		m = fr.size();
		if (fl == FL_SHORT_ICMP) begin
			repeat ($urandom_range(0, 7)) fr.push_back($urandom_range(0, 255));
		end else begin
			if (pr == PROTO_ICMP) begin
				fr.push_back(ity);
				fr.push_back($urandom_range(0, 255));
				fr.push_back(0); fr.push_back(0);
				put32($urandom);
			end
			repeat (ndata) fr.push_back($urandom_range(0, 255));
		end
		n = fr.size() - h;
		repeat (pad) fr.push_back(0);
		if (fl == FL_LEN) n = fr.size() - h + $urandom_range(1, 300);
		fr[h + 2] = n[15:8];
		fr[h + 3] = n[7:0];
		if (pr == PROTO_ICMP && fl != FL_SHORT_ICMP) begin
			c = ~sum_bytes(m, fr.size());
			if (fl == FL_ICMPSUM) c ^= 16'h0100;
			fr[m + 2] = c[15:8];
			fr[m + 3] = c[7:0];
		end
		c = ~sum_bytes(h, m);
		if (fl == FL_IPSUM) c ^= 16'h0001;
		fr[h + 10] = c[15:8];
		fr[h + 11] = c[7:0];
		if (fl == FL_IHL) fr[h] = {4'd4, 4'($urandom_range(0, 4))};
	endtask

	// ARP frame cut to keep payload bytes (28 is whole), then random padding.
	task automatic build_arp(logic [15:0] op, logic [31:0] sip, int keep, int pad);
		eth_head(KIND_ARP);
		fr.push_back(0); fr.push_back(1); fr.push_back(8); fr.push_back(0);
		fr.push_back(6); fr.push_back(4); fr.push_back(op[15:8]); fr.push_back(op[7:0]);
		repeat (6) fr.push_back($urandom_range(0, 255));
		put32(sip);
		repeat (10) fr.push_back($urandom_range(0, 255));
		while (fr.size() > 14 + keep) void'(fr.pop_back());
		repeat (pad) fr.push_back($urandom_range(0, 255));
	endtask

	task automatic rand_frame();
		int sel, hw;
		logic [7:0] ty;
		sel = $urandom_range(0, 99);
		hw = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5;
		ty = ($urandom_range(0, 1) == 1) ? ICMP_REQUEST : ICMP_REPLY;
		if ($urandom_range(0, 9) == 0) ty = $urandom_range(0, 255);
		if (sel < 45) begin
			build_ip(hw, PROTO_ICMP, own_ip, ty, $urandom_range(0, 24), $urandom_range(0, 3),
				FL_NONE);
		end else if (sel < 62) begin
			build_ip(hw, PROTO_ICMP, own_ip, ty, $urandom_range(0, 16), $urandom_range(0, 2),
				flaw_t'($urandom_range(FL_LEN, FL_IHL)));
		end else if (sel < 67) begin
			build_ip(5, $urandom_range(2, 255), own_ip, 0, $urandom_range(0, 16), 0, FL_NONE);
		end else if (sel < 77) begin
			build_arp(ARP_REPLY, gw_ip, 28, $urandom_range(0, 4));
		end else if (sel < 84) begin
			build_arp($urandom_range(0, 3), ($urandom_range(0, 1) == 1) ? gw_ip : $urandom,
				$urandom_range(18, 28), 0);
		end else if (sel < 87) begin
			build_arp(ARP_REPLY, gw_ip, $urandom_range(0, 17), 0);
		end else if (sel < 90) begin
			eth_head(KIND_IPV4);
			repeat ($urandom_range(0, 19)) fr.push_back($urandom_range(0, 255));
		end else if (sel < 94) begin
			eth_head(KIND_IPV4 ^ 16'($urandom_range(1, 65535)));
			repeat ($urandom_range(0, 30)) fr.push_back($urandom_range(0, 255));
		end else begin
			fr.delete();
			repeat ($urandom_range(1, 40)) fr.push_back($urandom_range(0, 255));
		end
		push_frame();
	endtask

	task automatic drain();
		while (pending.size() != 0 || s_tvalid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == CFG_HOST_IP) own_ip = v;
		else gw_ip = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic rand_phase(int nbytes);
		int start;
		start = pending.size() + words_in;
		while (pending.size() + words_in - start < nbytes) rand_frame();
	endtask

	// Stimulus: directed frames, then random phases at several address settings.
	initial begin
		own_ip = HOST_IP_RST;
		gw_ip = NHOP_IP_RST;
		gw_mac = '1;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		build_ip(5, PROTO_ICMP, own_ip, ICMP_REQUEST, 0, 0, FL_NONE); push_frame();
		build_ip(5, PROTO_ICMP, own_ip, ICMP_REPLY, 3, 0, FL_NONE); push_frame();
		build_ip(6, PROTO_ICMP, own_ip, 8'hff, 4, 1, FL_NONE); push_frame();
		build_ip(5, PROTO_ICMP, own_ip, ICMP_REQUEST, 2, 0, FL_LEN); push_frame();
		build_ip(5, PROTO_ICMP, own_ip, ICMP_REQUEST, 2, 0, FL_IPSUM); push_frame();
		build_ip(5, PROTO_ICMP, own_ip, ICMP_REQUEST, 2, 0, FL_ICMPSUM); push_frame();
		build_ip(5, PROTO_ICMP, own_ip, ICMP_REQUEST, 2, 0, FL_DEST); push_frame();
		build_ip(5, PROTO_ICMP, own_ip, ICMP_REQUEST, 0, 0, FL_SHORT_ICMP); push_frame();
		build_ip(5, PROTO_ICMP, own_ip, ICMP_REQUEST, 0, 0, FL_IHL); push_frame();
		build_ip(15, PROTO_ICMP, own_ip, ICMP_REQUEST, 0, 0, FL_NONE); push_frame();
		build_ip(5, 8'd17, own_ip, 0, 6, 0, FL_NONE); push_frame();
		build_arp(ARP_REPLY, gw_ip, 28, 0); push_frame();
		build_arp(ARP_REPLY, gw_ip, 17, 0); push_frame();
		build_arp(16'd1, gw_ip, 18, 0); push_frame();
		eth_head(KIND_IPV4); repeat (19) fr.push_back(8'hff); push_frame();
		eth_head(16'hffff); push_frame();
		fr.delete(); repeat (13) fr.push_back(8'h00); push_frame();
		fr.delete(); fr.push_back(8'hff); push_frame();
		drain();

		write_cfg(CFG_HOST_IP, $urandom);
		write_cfg(CFG_NHOP_IP, $urandom);
		rand_phase(415);
		drain();
		write_cfg(CFG_HOST_IP, 32'h0);
		write_cfg(CFG_NHOP_IP, 32'hffffffff);
		rand_phase(415);
		drain();
		write_cfg(CFG_HOST_IP, 32'hffffffff);
		write_cfg(CFG_NHOP_IP, 32'h0);
		idle_on = 1'b0;
		rand_phase(415);
		drain();

		$display("%0d bytes in, %0d verdicts checked; echo %0d, arp learned %0d, ip errors %0d",
			words_in, frames_checked, verdict_seen[V_ECHO_OK], verdict_seen[V_ARP_LEARN],
			verdict_seen[V_IP_LEN] + verdict_seen[V_IP_CKSUM] + verdict_seen[V_IP_DEST]);
		$display("covered ARP, IPv4, ICMP and malformed frames at four address settings");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Long receiver hold-off once plenty of words are queued, so the input backs up.
	initial begin
		@(posedge arst_n);
		while (pending.size() < 300) @(posedge clk);
		long_hold <= 1'b1;
		repeat (600) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
